FILE: rtl/core/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants of the page first-fit allocator core.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

    localparam int HEAP_PAGES   = 256;
    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 24;

    localparam int BYTES_W    = 21;
    localparam int PAGE_IN_W  = 8;
    localparam int START_W    = 8;
    localparam int HEAP_W     = 9;
    localparam int STATUS_W   = 2;

    localparam int PW         = $clog2(HEAP_PAGES);
    localparam int LW         = $clog2(HEAP_PAGES + 1);
    localparam int EW         = LW + 1;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int ROUND_ADD  = HEADER_BYTES + PAGE_BYTES - 1;
    localparam int AW         = BYTES_W + 1;
    localparam int NW         = AW - PAGE_SHIFT;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_BADFREE = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_NEED,
        S_A_INIT,
        S_A_RD,
        S_A_CHK,
        S_A_ADV,
        S_A_SPLIT,
        S_A_TAKE,
        S_A_GROW,
        S_F_CHK,
        S_F_BUSY,
        S_F_RD,
        S_F_WLK,
        S_F_ADV,
        S_F_PREV,
        S_F_NXT,
        S_F_NCHK,
        S_F_NBUSY,
        S_F_END,
        S_F_TRIM,
        S_DONE
    } t_state;

    typedef struct packed {
        logic          busy;
        logic [LW-1:0] len;
    } t_entry;

    typedef struct packed {
        logic [AW-1:0] a;
        logic [AW-1:0] b;
        logic          sub;
    } t_alu_req;

    typedef struct packed {
        logic [AW-1:0] sum;
        logic          ge;
    } t_alu_rsp;

    typedef struct packed {
        logic          we;
        logic [PW-1:0] waddr;
        t_entry        wdata;
        logic [PW-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        t_status       status;
        logic [PW-1:0] start;
        logic [LW-1:0] heap;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/pfa_alu.sv
// ----------------------------------------------------------------------------
// pfa_alu
// Shared add/subtract unit; the borrow of a subtract gives the compare.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_alu (
    input  wire pfa_pkg::t_alu_req i_req,
    output pfa_pkg::t_alu_rsp      o_rsp
);

    import pfa_pkg::*;

    logic [AW:0] w_ext;

    always_comb begin
        if (i_req.sub) begin
            w_ext = {1'b0, i_req.a} - {1'b0, i_req.b};
        end else begin
            w_ext = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
    end

    assign o_rsp.sum = w_ext[AW-1:0];
    assign o_rsp.ge  = ~w_ext[AW];

endmodule

`default_nettype wire

FILE: rtl/core/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer of the allocator: walks the chunk table, splits, merges and trims.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          i_operation,
    input  wire logic [pfa_pkg::BYTES_W-1:0]   i_request_bytes,
    input  wire logic [pfa_pkg::PAGE_IN_W-1:0] i_chunk_page,
    output logic                               o_stall,
    output pfa_pkg::t_alu_req                  o_alu_req,
    input  wire pfa_pkg::t_alu_rsp             i_alu_rsp,
    output pfa_pkg::t_ram_req                  o_ram,
    input  wire pfa_pkg::t_entry               i_rd_data,
    input  wire logic                          i_out_free,
    output logic                               o_done,
    output pfa_pkg::t_result                   o_result
);

    import pfa_pkg::*;

    t_state              r_state, n_state;
    logic [BYTES_W-1:0]  r_bytes, n_bytes;
    logic [PW-1:0]       r_page, n_page;
    logic [LW-1:0]       r_top, n_top;
    logic [NW-1:0]       r_need, n_need;
    logic [LW-1:0]       r_pos, n_pos;
    logic [PW-1:0]       r_prev, n_prev;
    logic                r_has_prev, n_has_prev;
    logic                r_prev_busy, n_prev_busy;
    logic [LW-1:0]       r_prev_len, n_prev_len;
    logic [LW-1:0]       r_len_p, n_len_p;
    logic [PW-1:0]       r_cur, n_cur;
    logic [LW-1:0]       r_cur_len, n_cur_len;
    logic [LW-1:0]       r_nxt, n_nxt;
    logic [LW-1:0]       r_diff, n_diff;
    logic [HEAP_PAGES-1:0] r_begins, n_begins;
    t_status             r_status, n_status;
    logic [PW-1:0]       r_start, n_start;
    logic                w_accept;
    logic [NW-1:0]       w_quot;

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign w_quot   = i_alu_rsp.sum[AW-1:PAGE_SHIFT];

    assign o_result.status = r_status;
    assign o_result.start  = r_start;
    assign o_result.heap   = r_top;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (t_op'(i_operation) == OP_FREE) ? S_F_CHK : S_A_NEED;
                end
            end
            S_A_NEED:  n_state = (r_top == '0) ? S_A_INIT : S_A_RD;
            S_A_INIT:  n_state = S_A_RD;
            S_A_RD:    n_state = i_alu_rsp.ge ? S_A_GROW : S_A_CHK;
            S_A_CHK: begin
                if (i_rd_data.len == '0) begin
                    n_state = S_A_GROW;
                end else if (!i_rd_data.busy && i_alu_rsp.ge) begin
                    n_state = (i_alu_rsp.sum[LW-1:0] != '0) ? S_A_SPLIT : S_A_TAKE;
                end else begin
                    n_state = S_A_ADV;
                end
            end
            S_A_ADV:   n_state = S_A_RD;
            S_A_SPLIT: n_state = S_A_TAKE;
            S_A_TAKE:  n_state = S_DONE;
            S_A_GROW:  n_state = S_DONE;
            S_F_CHK: begin
                n_state = (i_alu_rsp.ge || !r_begins[r_page]) ? S_DONE : S_F_BUSY;
            end
            S_F_BUSY:  n_state = i_rd_data.busy ? S_F_RD : S_DONE;
            S_F_RD:    n_state = i_alu_rsp.ge ? S_F_PREV : S_F_WLK;
            S_F_WLK:   n_state = (i_rd_data.len == '0) ? S_F_PREV : S_F_ADV;
            S_F_ADV:   n_state = S_F_RD;
            S_F_PREV:  n_state = S_F_NXT;
            S_F_NXT:   n_state = S_F_NCHK;
            S_F_NCHK: begin
                n_state = (!i_alu_rsp.ge && r_begins[r_nxt[PW-1:0]]) ? S_F_NBUSY : S_F_END;
            end
            S_F_NBUSY: n_state = S_F_END;
            S_F_END:   n_state = S_F_TRIM;
            S_F_TRIM:  n_state = S_DONE;
            S_DONE:    n_state = i_out_free ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_bytes     = r_bytes;
        n_page      = r_page;
        n_top       = r_top;
        n_need      = r_need;
        n_pos       = r_pos;
        n_prev      = r_prev;
        n_has_prev  = r_has_prev;
        n_prev_busy = r_prev_busy;
        n_prev_len  = r_prev_len;
        n_len_p     = r_len_p;
        n_cur       = r_cur;
        n_cur_len   = r_cur_len;
        n_nxt       = r_nxt;
        n_diff      = r_diff;
        n_begins    = r_begins;
        n_status    = r_status;
        n_start     = r_start;
        o_alu_req   = '0;
        o_ram       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_bytes = i_request_bytes;
                    n_page  = PW'(i_chunk_page);
                end
            end
            S_A_NEED: begin
                o_alu_req.a = AW'(r_bytes);
                o_alu_req.b = AW'(ROUND_ADD);
                n_need      = (w_quot == '0) ? NW'(1) : w_quot;
                n_pos       = '0;
            end
            S_A_INIT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = '0;
                o_ram.wdata = '{busy: 1'b0, len: LW'(1)};
                n_begins[0] = 1'b1;
                n_top       = LW'(1);
            end
            S_A_RD: begin
                o_alu_req   = '{a: AW'(r_pos), b: AW'(r_top), sub: 1'b1};
                o_ram.raddr = r_pos[PW-1:0];
            end
            S_A_CHK: begin
                o_alu_req = '{a: AW'(i_rd_data.len), b: AW'(r_need), sub: 1'b1};
                n_diff    = i_alu_rsp.sum[LW-1:0];
                n_len_p   = i_rd_data.len;
            end
            S_A_ADV: begin
                o_alu_req = '{a: AW'(r_pos), b: AW'(r_len_p), sub: 1'b0};
                n_pos     = i_alu_rsp.sum[LW-1:0];
            end
            S_A_SPLIT: begin
                o_alu_req   = '{a: AW'(r_pos), b: AW'(r_need), sub: 1'b0};
                o_ram.we    = 1'b1;
                o_ram.waddr = i_alu_rsp.sum[PW-1:0];
                o_ram.wdata = '{busy: 1'b0, len: r_diff};
                n_begins[i_alu_rsp.sum[PW-1:0]] = 1'b1;
            end
            S_A_TAKE: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_pos[PW-1:0];
                o_ram.wdata = '{busy: 1'b1, len: r_need[LW-1:0]};
                n_status    = ST_OK;
                n_start     = r_pos[PW-1:0];
            end
            S_A_GROW: begin
                o_alu_req = '{a: AW'(r_top), b: AW'(r_need), sub: 1'b0};
                if (i_alu_rsp.sum > AW'(HEAP_PAGES)) begin
                    n_status = ST_OOM;
                    n_start  = '0;
                end else begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_top[PW-1:0];
                    o_ram.wdata = '{busy: 1'b1, len: r_need[LW-1:0]};
                    n_begins[r_top[PW-1:0]] = 1'b1;
                    n_status    = ST_OK;
                    n_start     = r_top[PW-1:0];
                    n_top       = i_alu_rsp.sum[LW-1:0];
                end
            end
            S_F_CHK: begin
                o_alu_req   = '{a: AW'(r_page), b: AW'(r_top), sub: 1'b1};
                o_ram.raddr = r_page;
                n_status    = ST_BADFREE;
                n_start     = '0;
            end
            S_F_BUSY: begin
                if (i_rd_data.busy) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_page;
                    o_ram.wdata = '{busy: 1'b0, len: i_rd_data.len};
                    n_len_p     = i_rd_data.len;
                    n_pos       = '0;
                    n_has_prev  = 1'b0;
                end
            end
            S_F_RD: begin
                o_alu_req   = '{a: AW'(r_pos), b: AW'(r_page), sub: 1'b1};
                o_ram.raddr = r_pos[PW-1:0];
            end
            S_F_WLK: begin
                if (i_rd_data.len != '0) begin
                    n_prev      = r_pos[PW-1:0];
                    n_has_prev  = 1'b1;
                    n_prev_busy = i_rd_data.busy;
                    n_prev_len  = i_rd_data.len;
                end
            end
            S_F_ADV: begin
                o_alu_req = '{a: AW'(r_pos), b: AW'(r_prev_len), sub: 1'b0};
                n_pos     = i_alu_rsp.sum[LW-1:0];
            end
            S_F_PREV: begin
                o_alu_req = '{a: AW'(r_prev_len), b: AW'(r_len_p), sub: 1'b0};
                if (r_has_prev && !r_prev_busy) begin
                    o_ram.we         = 1'b1;
                    o_ram.waddr      = r_prev;
                    o_ram.wdata      = '{busy: 1'b0, len: i_alu_rsp.sum[LW-1:0]};
                    n_begins[r_page] = 1'b0;
                    n_cur            = r_prev;
                    n_cur_len        = i_alu_rsp.sum[LW-1:0];
                end else begin
                    n_cur     = r_page;
                    n_cur_len = r_len_p;
                end
            end
            S_F_NXT, S_F_END: begin
                o_alu_req = '{a: AW'(r_cur), b: AW'(r_cur_len), sub: 1'b0};
                n_nxt     = i_alu_rsp.sum[LW-1:0];
            end
            S_F_NCHK: begin
                o_alu_req   = '{a: AW'(r_nxt), b: AW'(r_top), sub: 1'b1};
                o_ram.raddr = r_nxt[PW-1:0];
            end
            S_F_NBUSY: begin
                o_alu_req = '{a: AW'(r_cur_len), b: AW'(i_rd_data.len), sub: 1'b0};
                if (!i_rd_data.busy) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_cur;
                    o_ram.wdata = '{busy: 1'b0, len: i_alu_rsp.sum[LW-1:0]};
                    n_begins[r_nxt[PW-1:0]] = 1'b0;
                    n_cur_len   = i_alu_rsp.sum[LW-1:0];
                end
            end
            S_F_TRIM: begin
                o_alu_req = '{a: AW'(r_nxt), b: AW'(r_top), sub: 1'b1};
                n_status  = ST_OK;
                n_start   = '0;
                if (i_alu_rsp.ge) begin
                    n_begins[r_cur] = 1'b0;
                    n_top           = LW'(r_cur);
                end
            end
            S_DONE: begin
                n_status = r_status;
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_top    <= '0;
            r_begins <= '0;
        end else begin
            r_state  <= n_state;
            r_top    <= n_top;
            r_begins <= n_begins;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes     <= n_bytes;
        r_page      <= n_page;
        r_need      <= n_need;
        r_pos       <= n_pos;
        r_prev      <= n_prev;
        r_has_prev  <= n_has_prev;
        r_prev_busy <= n_prev_busy;
        r_prev_len  <= n_prev_len;
        r_len_p     <= n_len_p;
        r_cur       <= n_cur;
        r_cur_len   <= n_cur_len;
        r_nxt       <= n_nxt;
        r_diff      <= n_diff;
        r_status    <= n_status;
        r_start     <= n_start;
    end

endmodule

`default_nettype wire

FILE: rtl/core/page_first_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// page_first_fit_allocator_core
// Page-granular first-fit heap allocator with coalescing and heap trim.
// ----------------------------------------------------------------------------
// One word in gives one word out. The core holds one request at a time and
// stalls its input until that request's result is loaded into the output
// register. An allocate walks the chunk table to the first free chunk that
// fits, taking it whole or splitting off a remainder, and grows the heap or
// reports out of memory when no chunk fits. An allocate into an empty heap
// first sets up its first page. A free of a bad page is refused. A good free
// walks the chunks below the freed page, merges with a free chunk before it,
// checks the next chunk for a merge and trims the heap when the merged chunk
// reaches its top. The core passes through its idle state before it takes
// the next word. The walk over the chunk table reads one entry per read of
// the chunk RAM, with the shared adder stepping the address. A result that
// waits on a stalled output holds the core in its last state. The result
// sits in an output register, so the next request is taken while it waits.
`default_nettype none

module page_first_fit_allocator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_operation,
    input  wire logic [pfa_pkg::BYTES_W-1:0]   i_request_bytes,
    input  wire logic [pfa_pkg::PAGE_IN_W-1:0] i_chunk_page,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [pfa_pkg::STATUS_W-1:0]       o_status,
    output logic [pfa_pkg::START_W-1:0]        o_start_page,
    output logic [pfa_pkg::HEAP_W-1:0]         o_heap_pages
);

    import pfa_pkg::*;

    t_alu_req         w_alu_req;
    t_alu_rsp         w_alu_rsp;
    t_ram_req         w_ram;
    logic [EW-1:0]    w_rd_raw;
    t_entry           w_rd_data;
    logic             w_done;
    logic             w_out_free;
    t_result          w_result;

    logic                r_valid;
    logic [STATUS_W-1:0] r_status;
    logic [START_W-1:0]  r_start;
    logic [HEAP_W-1:0]   r_heap;

    assign w_out_free = !r_valid || !i_stall;
    assign w_rd_data  = t_entry'(w_rd_raw);

    pfa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_operation     (i_operation),
        .i_request_bytes (i_request_bytes),
        .i_chunk_page    (i_chunk_page),
        .o_stall         (o_stall),
        .o_alu_req       (w_alu_req),
        .i_alu_rsp       (w_alu_rsp),
        .o_ram           (w_ram),
        .i_rd_data       (w_rd_data),
        .i_out_free      (w_out_free),
        .o_done          (w_done),
        .o_result        (w_result)
    );

    pfa_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    pfa_ram #(
        .WIDTH (EW),
        .DEPTH (HEAP_PAGES)
    ) u_chunk_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_done && w_out_free) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_out_free) begin
            r_status <= w_result.status;
            r_start  <= START_W'(w_result.start);
            r_heap   <= HEAP_W'(w_result.heap);
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_start_page = r_start;
    assign o_heap_pages = r_heap;

endmodule

`default_nettype wire
